// ===== design/nta_pkg.sv =====
// ----------------------------------------------------------------------------
// Neighbor table package
// Shared widths, codes and types for the neighbor table with aging.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int unsigned ID_W        = 3;
  localparam int unsigned AGE_W       = 4;
  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W       = 4;   // addresses MAX_ENTRIES entries
  localparam int unsigned CNT_W       = 5;   // holds 0..MAX_ENTRIES
  localparam int unsigned MAP_W       = 8;   // one bit per id
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 4;

  localparam logic [AGE_W-1:0] AGE_MAX   = 4'hF;
  localparam logic [AGE_W-1:0] THR_RESET = 4'd4;
  localparam logic [ID_W-1:0]  OWN_RESET = 3'd0;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OWN_ID  = 2'd1;

  // request kinds
  localparam logic KIND_HEARTBEAT = 1'b0;
  localparam logic KIND_TICK      = 1'b1;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int unsigned ENTRY_W = AGE_W + ID_W;

  // result of the shared entry unit
  typedef struct packed {
    logic             match;
    logic             expired;
    logic [AGE_W-1:0] age_next;
  } alu_res_t;

endpackage

// ===== design/nta_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nta_entry_alu.sv =====
// ----------------------------------------------------------------------------
// Entry unit
// Compare one table entry against the sender, and age it against the timeout.
// ----------------------------------------------------------------------------
module nta_entry_alu (
  input  nta_pkg::entry_t                 entry_i,
  input  logic [nta_pkg::ID_W-1:0]        sender_i,
  input  logic [nta_pkg::AGE_W-1:0]       threshold_i,
  output nta_pkg::alu_res_t               res_o
);

  logic [nta_pkg::AGE_W-1:0] age_inc;

  // saturate at the top of the age range
  assign age_inc = (entry_i.age == nta_pkg::AGE_MAX) ? entry_i.age
                                                     : entry_i.age + 1'b1;

  assign res_o.match    = (entry_i.id == sender_i);
  assign res_o.age_next = age_inc;
  assign res_o.expired  = (age_inc >= threshold_i);

endmodule

// ===== design/neighbor_table_with_aging_unit.sv =====
// ----------------------------------------------------------------------------
// Neighbor table with aging
// Ordered table of neighbor ids with heartbeat refresh and tick timeout.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Contents
// s_axis   in   s_tvalid/s_tready    tuser: kind, tdata: sender_id
// m_axis   out  m_tvalid/m_tready    tdata: count, map, drop flag, removed
// cfg      in   cfg_valid/cfg_ready  register index and write data
//
// A request is accepted in the idle state; the live entries are then read in
// order through the single read port of the entry RAM and checked as the
// registered read data returns, and the final state loads the result register.
// The entry RAM needs no clearing after reset; only entries below the live
// count are ever read. The next request is accepted while a result still
// waits on m_axis; a stalled result holds the sequencer in its final state.
//
module neighbor_table_with_aging_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request stream
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  input  logic [7:0]                         s_tdata_i,  // [2:0] sender_id
  input  logic [0:0]                         s_tuser_i,  // [0] kind
  // result stream
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // [4:0] neighbor_count, [12:5] presence_map, [13] table_full_drop,
  // [18:14] removed_count
  output logic [23:0]                        m_tdata_o,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nta_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [nta_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  // configuration
  logic [nta_pkg::AGE_W-1:0] thr_q;
  logic [nta_pkg::ID_W-1:0]  own_id_q;

  // table state
  logic [nta_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [nta_pkg::MAP_W-1:0] map_q, map_d;

  // per-request working state
  logic                      kind_q, kind_d;
  logic [nta_pkg::ID_W-1:0]  sender_q, sender_d;
  logic                      drop_q, drop_d;
  logic [nta_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [nta_pkg::CNT_W-1:0] keep_q, keep_d;
  logic [nta_pkg::CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic                      chk_vld_q, chk_vld_d;
  logic [nta_pkg::IDX_W-1:0] chk_idx_q, chk_idx_d;

  // result register
  logic        out_vld_q, out_vld_d;
  logic [23:0] out_data_q, out_data_d;

  // RAM ports
  logic                       ram_we, ram_re;
  logic [nta_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
  nta_pkg::entry_t            ram_wdata, ram_rdata;
  logic [nta_pkg::ENTRY_W-1:0] ram_rdata_raw;

  nta_pkg::alu_res_t          alu_res;

  logic                      s_fire;
  logic                      chk_last;
  logic [nta_pkg::MAP_W-1:0] own_bit;
  logic [nta_pkg::ID_W-1:0]  in_sender;

  assign s_tready_o  = (state_q == ST_IDLE);
  assign s_fire      = s_tvalid_i & s_tready_o;
  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = out_vld_q;
  assign m_tdata_o   = out_data_q;
  assign in_sender   = s_tdata_i[nta_pkg::ID_W-1:0];

  // ---------------------------------------------------------------------------
  // Entry storage and the shared compare/age unit
  // ---------------------------------------------------------------------------
  nta_ram #(
    .WIDTH (nta_pkg::ENTRY_W),
    .DEPTH (nta_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = nta_pkg::entry_t'(ram_rdata_raw);

  nta_entry_alu u_alu (
    .entry_i     (ram_rdata),
    .sender_i    (sender_q),
    .threshold_i (thr_q),
    .res_o       (alu_res)
  );

  // the entry under check is the last live one
  assign chk_last = ({1'b0, chk_idx_q} + 1'b1) == cnt_q;

  always_comb begin
    own_bit           = '0;
    own_bit[own_id_q] = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    map_d      = map_q;
    kind_d     = kind_q;
    sender_d   = sender_q;
    drop_d     = drop_q;
    rem_d      = rem_q;
    keep_d     = keep_q;
    rd_ptr_d   = rd_ptr_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    out_vld_d  = out_vld_q & ~m_tready_i;
    out_data_d = out_data_q;

    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = rd_ptr_q[nta_pkg::IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          kind_d   = s_tuser_i[0];
          sender_d = in_sender;
          drop_d   = 1'b0;
          rem_d    = '0;
          keep_d   = '0;
          rd_ptr_d = '0;
          state_d  = ST_SCAN;
          if (cnt_q == '0) begin
            // empty table: append the sender at once, a tick has no work
            state_d = ST_FIN;
            if (s_tuser_i[0] == nta_pkg::KIND_HEARTBEAT) begin
              ram_we           = 1'b1;
              ram_waddr        = '0;
              ram_wdata.id     = in_sender;
              ram_wdata.age    = '0;
              map_d[in_sender] = 1'b1;
              cnt_d            = nta_pkg::CNT_W'(1);
            end
          end
        end
      end

      ST_SCAN: begin
        // issue the next read while the previous entry is checked
        if (rd_ptr_q < cnt_q) begin
          ram_re    = 1'b1;
          rd_ptr_d  = rd_ptr_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_ptr_q[nta_pkg::IDX_W-1:0];
        end

        if (chk_vld_q) begin
          if (kind_q == nta_pkg::KIND_HEARTBEAT) begin
            if (alu_res.match) begin
              // known sender: refresh its age
              ram_we        = 1'b1;
              ram_waddr     = chk_idx_q;
              ram_wdata.id  = sender_q;
              ram_wdata.age = '0;
              chk_vld_d     = 1'b0;
              state_d       = ST_FIN;
            end else if (chk_last) begin
              chk_vld_d = 1'b0;
              state_d   = ST_FIN;
              if (!cnt_q[nta_pkg::CNT_W-1]) begin
                // append behind the last live entry
                ram_we          = 1'b1;
                ram_waddr       = cnt_q[nta_pkg::IDX_W-1:0];
                ram_wdata.id    = sender_q;
                ram_wdata.age   = '0;
                map_d[sender_q] = 1'b1;
                cnt_d           = cnt_q + 1'b1;
              end else begin
                drop_d = 1'b1;
              end
            end
          end else begin
            if (alu_res.expired) begin
              // drop the entry; ids are unique so its map bit goes too
              rem_d              = rem_q + 1'b1;
              map_d[ram_rdata.id] = 1'b0;
            end else begin
              // compact: move survivors down to the keep pointer
              ram_we        = 1'b1;
              ram_waddr     = keep_q[nta_pkg::IDX_W-1:0];
              ram_wdata.id  = ram_rdata.id;
              ram_wdata.age = alu_res.age_next;
              keep_d        = keep_q + 1'b1;
            end
            if (chk_last) begin
              cnt_d     = alu_res.expired ? keep_q : keep_q + 1'b1;
              chk_vld_d = 1'b0;
              state_d   = ST_FIN;
            end
          end
        end
      end

      ST_FIN: begin
        // load the result once the output register is free
        if (!out_vld_q || m_tready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = {5'd0, rem_q, drop_q, map_q | own_bit, cnt_q};
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      map_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      thr_q     <= nta_pkg::THR_RESET;
      own_id_q  <= nta_pkg::OWN_RESET;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      map_q     <= map_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          nta_pkg::REG_TIMEOUT: thr_q    <= cfg_wdata_i;
          nta_pkg::REG_OWN_ID:  own_id_q <= cfg_wdata_i[nta_pkg::ID_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    sender_q   <= sender_d;
    drop_q     <= drop_d;
    rem_q      <= rem_d;
    keep_q     <= keep_d;
    rd_ptr_q   <= rd_ptr_d;
    chk_idx_q  <= chk_idx_d;
    out_data_q <= out_data_d;
  end

endmodule
